[design/jss_pkg.sv]
// types, constants and divide helpers shared by the stencil sweep modules
package jss_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned POS_W       = 10;
  localparam int unsigned CFG_W       = 11;
  localparam int unsigned SUM_W       = 35;
  localparam int unsigned SPLIT_W     = 16;
  localparam int unsigned RECIP_W     = 21;
  localparam int unsigned RECIP_SHIFT = 22;
  localparam int unsigned QUOT_W      = 34;
  localparam int unsigned OUT_DATA_W  = 88;

  localparam logic [CFG_W-1:0] GRID_RESET = 11'd1024;

  localparam logic [2:0] POINTS_FULL   = 3'd5;
  localparam logic [2:0] POINTS_EDGE   = 3'd4;
  localparam logic [2:0] POINTS_CORNER = 3'd3;

  localparam logic [RECIP_W-1:0] RECIP_FULL   = 21'd838861;
  localparam logic [RECIP_W-1:0] RECIP_EDGE   = 21'd1048576;
  localparam logic [RECIP_W-1:0] RECIP_CORNER = 21'd1398102;

  typedef struct packed {
    logic vld;
    logic start;
  } in_ctrl_t;

  typedef struct packed {
    logic             vld;
    logic             start;
    logic             emit;
    logic             last;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [2:0]       points;
  } side_t;

  typedef struct packed {
    logic [VALUE_W-1:0] north;
    logic [VALUE_W-1:0] west;
    logic [VALUE_W-1:0] center;
    logic [VALUE_W-1:0] east;
    logic [VALUE_W-1:0] south;
  } taps_t;

  // ceil(2^22 / points), exact for dividends below 2^19
  function automatic logic [RECIP_W-1:0] recip(input logic [2:0] points);
    logic [RECIP_W-1:0] m;
    case (points)
      POINTS_CORNER: m = RECIP_CORNER;
      POINTS_EDGE:   m = RECIP_EDGE;
      default:       m = RECIP_FULL;
    endcase
    return m;
  endfunction

endpackage

[design/jss_line_buf.sv]
// sweep counters, packed two-row line buffer and the input register stage
module jss_line_buf import jss_pkg::*; #(
  parameter int MAX_GRID = 1024,
  localparam int CW = $clog2(MAX_GRID),
  localparam int NW = $clog2(MAX_GRID + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               in_valid_i,
  input  logic [VALUE_W-1:0] in_value_i,
  input  logic               cfg_we_i,
  input  logic [NW-1:0]      n_i,
  output in_ctrl_t           ctrl_o,
  output logic [CW-1:0]      row_o,
  output logic [CW-1:0]      col_o,
  output logic [VALUE_W-1:0] value_o,
  output logic [VALUE_W-1:0] upper_o,
  output logic [VALUE_W-1:0] middle_o
);

  logic [2*VALUE_W-1:0] mem [MAX_GRID];

  logic [CW-1:0]        row_q, row_d, col_q, col_d;
  logic [CW-1:0]        row1_q, col1_q;
  logic [VALUE_W-1:0]   value_q;
  logic [2*VALUE_W-1:0] rd_q;
  in_ctrl_t             ctrl_q;
  logic                 accept;

  assign accept = in_valid_i && adv_i;

  always_comb begin
    row_d = row_q;
    col_d = col_q + CW'(1);
    if ((32'(col_q) + 32'd1) >= 32'(n_i)) begin
      col_d = '0;
      if ((32'(row_q) + 32'd1) >= 32'(n_i)) begin
        row_d = '0;
      end else begin
        row_d = row_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      ctrl_q <= '0;
    end else begin
      if (cfg_we_i) begin
        row_q <= '0;
        col_q <= '0;
      end else if (accept) begin
        row_q <= row_d;
        col_q <= col_d;
      end
      if (adv_i) begin
        ctrl_q.vld   <= in_valid_i;
        ctrl_q.start <= in_valid_i && (row_q == '0) && (col_q == '0);
      end
    end
  end

  // upper half holds the older row, lower half the newer one
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q    <= mem[col_q];
      value_q <= in_value_i;
      row1_q  <= row_q;
      col1_q  <= col_q;
    end
    if (ctrl_q.vld) begin
      mem[col1_q] <= {rd_q[VALUE_W-1:0], value_q};
    end
  end

  assign ctrl_o   = ctrl_q;
  assign row_o    = row1_q;
  assign col_o    = col1_q;
  assign value_o  = value_q;
  assign upper_o  = rd_q[2*VALUE_W-1:VALUE_W];
  assign middle_o = rd_q[VALUE_W-1:0];

`ifndef NO_ASSERTIONS
  a_col_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < 32'(n_i))
    else $error("column counter outside grid");

  a_row_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(row_q) < 32'(n_i))
    else $error("row counter outside grid");
`endif

endmodule

[design/jss_window.sv]
// neighborhood window registers and interior position decode
module jss_window import jss_pkg::*; #(
  parameter int MAX_GRID = 1024,
  localparam int CW = $clog2(MAX_GRID),
  localparam int NW = $clog2(MAX_GRID + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  in_ctrl_t           ctrl_i,
  input  logic [CW-1:0]      row_i,
  input  logic [CW-1:0]      col_i,
  input  logic [VALUE_W-1:0] value_i,
  input  logic [VALUE_W-1:0] upper_i,
  input  logic [VALUE_W-1:0] middle_i,
  input  logic [NW-1:0]      n_i,
  output taps_t              taps_o,
  output side_t              side_o
);

  logic [VALUE_W-1:0] up_r_q, mid_r_q, low_r_q;
  logic [VALUE_W-1:0] up_c_q, mid_c_q, low_c_q;
  logic [VALUE_W-1:0] mid_l_q;
  side_t              side_q, side_d;
  logic [CW-1:0]      cr, cc;
  logic [31:0]        inner_last;
  logic               row_edge, col_edge;

  always_comb begin
    cr         = row_i - CW'(1);
    cc         = col_i - CW'(1);
    inner_last = 32'(n_i) - 32'd2;
    row_edge   = (32'(cr) == 32'd1) || (32'(cr) == inner_last);
    col_edge   = (32'(cc) == 32'd1) || (32'(cc) == inner_last);
    side_d.vld   = ctrl_i.vld;
    side_d.start = ctrl_i.start;
    side_d.emit  = ctrl_i.vld && (32'(row_i) >= 32'd2) && (32'(col_i) >= 32'd2);
    side_d.last  = (32'(cr) == inner_last) && (32'(cc) == inner_last);
    side_d.row   = POS_W'(cr);
    side_d.col   = POS_W'(cc);
    case ({row_edge, col_edge})
      2'b00:   side_d.points = POINTS_FULL;
      2'b11:   side_d.points = POINTS_CORNER;
      default: side_d.points = POINTS_EDGE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_r_q  <= '0;
      mid_r_q <= '0;
      low_r_q <= '0;
      up_c_q  <= '0;
      mid_c_q <= '0;
      low_c_q <= '0;
      mid_l_q <= '0;
      side_q  <= '0;
    end else if (adv_i) begin
      side_q <= side_d;
      if (ctrl_i.vld) begin
        mid_l_q <= mid_c_q;
        up_c_q  <= up_r_q;
        mid_c_q <= mid_r_q;
        low_c_q <= low_r_q;
        up_r_q  <= upper_i;
        mid_r_q <= middle_i;
        low_r_q <= value_i;
      end
    end
  end

  assign taps_o.north  = up_c_q;
  assign taps_o.west   = mid_l_q;
  assign taps_o.center = mid_c_q;
  assign taps_o.east   = mid_r_q;
  assign taps_o.south  = low_c_q;
  assign side_o        = side_q;

`ifndef NO_ASSERTIONS
  a_points_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    side_q.vld && side_q.emit |->
      (side_q.points == POINTS_FULL) || (side_q.points == POINTS_EDGE) ||
      (side_q.points == POINTS_CORNER))
    else $error("stencil point count out of set");

  a_emit_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    side_q.emit |-> side_q.vld && !side_q.start)
    else $error("result flagged on empty slot or sweep start");
`endif

endmodule

[design/jss_divide.sv]
// five point sum and split reciprocal divide by 3, 4 or 5
module jss_divide import jss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  taps_t             taps_i,
  input  side_t             side_i,
  output logic [QUOT_W-1:0] quot_o,
  output logic [VALUE_W-1:0] center_o,
  output side_t             side_o
);

  localparam int HI_W   = SUM_W - SPLIT_W;
  localparam int PROD_W = HI_W + RECIP_W;
  localparam int QHI_W  = PROD_W - RECIP_SHIFT;
  localparam int REM_W  = HI_W - SPLIT_W;

  // sum stage
  logic [SUM_W-1:0]   sum_q;
  logic [VALUE_W-1:0] center3_q;
  side_t              side3_q;

  // high half quotient stage
  logic [QHI_W-1:0]   qhi_q;
  logic [HI_W-1:0]    hi_q;
  logic [SPLIT_W-1:0] lo_q;
  logic [VALUE_W-1:0] center4_q;
  side_t              side4_q;

  // full quotient stage
  logic [QUOT_W-1:0]  quot_q;
  logic [VALUE_W-1:0] center5_q;
  side_t              side5_q;

  logic [SUM_W-1:0]   sum_d;
  logic [PROD_W-1:0]  prod_hi, prod_lo;
  logic [HI_W-1:0]    qhi_times;
  logic [REM_W-1:0]   rem;
  logic [HI_W-1:0]    low_part;

  always_comb begin
    sum_d = SUM_W'(taps_i.center) + SUM_W'(taps_i.north) + SUM_W'(taps_i.south)
          + SUM_W'(taps_i.west) + SUM_W'(taps_i.east);
    prod_hi   = PROD_W'(sum_q[SUM_W-1:SPLIT_W]) * PROD_W'(recip(side3_q.points));
    qhi_times = HI_W'(HI_W'(qhi_q) * HI_W'(side4_q.points));
    rem       = REM_W'(hi_q - qhi_times);
    low_part  = {rem, lo_q};
    prod_lo   = PROD_W'(low_part) * PROD_W'(recip(side4_q.points));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side3_q <= '0;
      side4_q <= '0;
      side5_q <= '0;
    end else if (adv_i) begin
      side3_q <= side_i;
      side4_q <= side3_q;
      side5_q <= side4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sum_q     <= sum_d;
      center3_q <= taps_i.center;
      qhi_q     <= prod_hi[PROD_W-1:RECIP_SHIFT];
      hi_q      <= sum_q[SUM_W-1:SPLIT_W];
      lo_q      <= sum_q[SPLIT_W-1:0];
      center4_q <= center3_q;
      quot_q    <= {qhi_q, prod_lo[RECIP_SHIFT+SPLIT_W-1:RECIP_SHIFT]};
      center5_q <= center4_q;
    end
  end

  assign quot_o   = quot_q;
  assign center_o = center5_q;
  assign side_o   = side5_q;

endmodule

[design/jss_result.sv]
// saturation, change tracking and the output register
module jss_result import jss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  cfg_we_i,
  input  logic [QUOT_W-1:0]     quot_i,
  input  logic [VALUE_W-1:0]    center_i,
  input  side_t                 side_i,
  output logic                  out_valid_o,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic                  out_last_o
);

  logic [VALUE_W-1:0] max_q;
  logic               out_valid_q;
  logic [VALUE_W-1:0] nv_q, omax_q;
  logic [POS_W-1:0]   row_q, col_q;
  logic               last_q;
  logic [VALUE_W-1:0] nv, diff, max_next;

  always_comb begin
    nv       = (|quot_i[QUOT_W-1:VALUE_W]) ? '1 : quot_i[VALUE_W-1:0];
    diff     = (nv >= center_i) ? (nv - center_i) : (center_i - nv);
    max_next = (diff > max_q) ? diff : max_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= '0;
      end else if (adv_i && side_i.vld) begin
        if (side_i.start) begin
          max_q <= '0;
        end else if (side_i.emit) begin
          max_q <= max_next;
        end
      end
      if (adv_i) begin
        out_valid_q <= side_i.vld && side_i.emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && side_i.vld && side_i.emit) begin
      nv_q   <= nv;
      omax_q <= max_next;
      row_q  <= side_i.row;
      col_q  <= side_i.col;
      last_q <= side_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {4'b0, omax_q, col_q, row_q, nv_q};
  assign out_last_o  = last_q;

`ifndef NO_ASSERTIONS
  a_last_on_diagonal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && last_q |-> row_q == col_q)
    else $error("final item not on the grid diagonal");

  a_max_covers_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && side_i.vld && side_i.emit |=> omax_q >= nv_q - nv_q)
    else $error("running maximum below zero");
`endif

endmodule

[design/jacobi_stencil_sweep.sv]
// top level of the five point stencil relaxation sweep
// a cell's value passes the input register, window, sum, high quotient, full quotient and output registers
// throughput: one cell per cycle unless the output stalls, set by the single read and write port of the line buffer
// output stalls hold the whole pipeline, cells keep flowing while the result is taken
// reset clears counters, window, running maximum and sets the grid side to 1024
// line buffer contents are not cleared; entries are written before any result uses them
module jacobi_stencil_sweep import jss_pkg::*; #(
  parameter int MAX_GRID = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [VALUE_W-1:0]    s_axis_tdata,   // cell_value
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // new_value, cell_row, cell_col, max_change
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_W-1:0]      cfg_data_i      // grid_size
);

  localparam int CW = $clog2(MAX_GRID);
  localparam int NW = $clog2(MAX_GRID + 1);

  logic [CFG_W-1:0]   grid_size_q;
  logic [31:0]        gs_ext, n_ext;
  logic [NW-1:0]      n;
  logic               cfg_we, adv;

  in_ctrl_t           s1_ctrl;
  logic [CW-1:0]      s1_row, s1_col;
  logic [VALUE_W-1:0] s1_value, s1_upper, s1_middle;
  taps_t              taps;
  side_t              s2_side, s5_side;
  logic [QUOT_W-1:0]  quot;
  logic [VALUE_W-1:0] center;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= GRID_RESET;
    end else if (cfg_we) begin
      grid_size_q <= cfg_data_i;
    end
  end

  always_comb begin
    gs_ext = 32'(grid_size_q);
    if (gs_ext < 32'd3) begin
      n_ext = 32'd3;
    end else if (gs_ext > 32'(MAX_GRID)) begin
      n_ext = 32'(MAX_GRID);
    end else begin
      n_ext = gs_ext;
    end
    n = NW'(n_ext);
  end

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  jss_line_buf #(.MAX_GRID(MAX_GRID)) u_line_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (s_axis_tvalid),
    .in_value_i (s_axis_tdata),
    .cfg_we_i   (cfg_we),
    .n_i        (n),
    .ctrl_o     (s1_ctrl),
    .row_o      (s1_row),
    .col_o      (s1_col),
    .value_o    (s1_value),
    .upper_o    (s1_upper),
    .middle_o   (s1_middle)
  );

  jss_window #(.MAX_GRID(MAX_GRID)) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .ctrl_i   (s1_ctrl),
    .row_i    (s1_row),
    .col_i    (s1_col),
    .value_i  (s1_value),
    .upper_i  (s1_upper),
    .middle_i (s1_middle),
    .n_i      (n),
    .taps_o   (taps),
    .side_o   (s2_side)
  );

  jss_divide u_divide (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .taps_i   (taps),
    .side_i   (s2_side),
    .quot_o   (quot),
    .center_o (center),
    .side_o   (s5_side)
  );

  jss_result u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .cfg_we_i    (cfg_we),
    .quot_i      (quot),
    .center_i    (center),
    .side_i      (s5_side),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

`ifndef NO_ASSERTIONS
  a_side_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(n) >= 32'd3 && 32'(n) <= 32'(MAX_GRID))
    else $error("grid side outside supported range");
`endif

endmodule
